/* hw/rtl/lcsl_pkg.sv */
package lcsl_pkg;

	// Longest reference or other string taken into the comparison
	localparam int MAX_LEN = 256;

	// Field widths
	localparam int CHAR_W = 16;
	localparam int CAP_W  = 9;
	localparam int OUT_W  = 9;

	// Run lengths and counts reach MAX_LEN itself
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	// Cell index
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	// Common width for comparing counts against the cap
	localparam int CMP_W = (LEN_W > CAP_W) ? LEN_W : CAP_W;

	// Request actions
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_PROC   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	// Control broadcast to every cell of the row
	typedef struct packed {
		logic              proc;
		logic              clear;
		logic [CHAR_W-1:0] ch;
	} lcsl_ctrl_t;

endpackage

/* hw/rtl/longest_common_substring_len.sv */
// Longest common substring length over two strings of 16-bit characters.
// Write compare_cap through cfg_wr_en/cfg_wr_data while idle. Each request
// (start high while busy is low) carries an action: load a reference
// character, process a character of the other string, or finish. Load and
// process may arrive in every cycle, since each reference column is a cell
// of a row that updates all at once. Finish raises busy while the running
// best walks down the row of cells, one cell per cycle; done then pulses
// for exactly one cycle with best_length, the block clears, and busy drops
// in that same cycle. There is no way to hold the result off: capture it
// on done. Characters beyond the cap (min of compare_cap and MAX_LEN)
// are ignored.
module longest_common_substring_len import lcsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [CHAR_W-1:0] char_value,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data,
	output logic              done,
	output logic [OUT_W-1:0]  best_length
);

	logic [CAP_W-1:0] cap_q;
	logic [LEN_W-1:0] ref_count_q;
	logic [LEN_W-1:0] other_count_q;
	logic             busy_q;
	logic [LEN_W-1:0] drain_q;
	logic             done_q;
	logic [OUT_W-1:0] best_q;

	logic             accept;
	logic             do_load;
	logic             do_proc;
	logic             do_finish;
	logic             drain_end;
	logic [CMP_W-1:0] eff_cap;
	logic [LEN_W-1:0] row_best;
	lcsl_ctrl_t       ctrl;

	assign accept    = start && !busy_q;
	assign drain_end = busy_q && (drain_q == '0);
	assign eff_cap   = (CMP_W'(cap_q) > CMP_W'(MAX_LEN)) ? CMP_W'(MAX_LEN) : CMP_W'(cap_q);

	// Decode the request against the cap
	always_comb begin
		do_load   = 1'b0;
		do_proc   = 1'b0;
		do_finish = 1'b0;
		if (accept) begin
			unique case (action)
				ACT_LOAD:   do_load   = CMP_W'(ref_count_q) < eff_cap;
				ACT_PROC:   do_proc   = CMP_W'(other_count_q) < eff_cap;
				ACT_FINISH: do_finish = 1'b1;
				default:    ;
			endcase
		end
	end

	assign ctrl.proc  = do_proc;
	assign ctrl.clear = drain_end;
	assign ctrl.ch    = char_value;

	// Hold the cap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(MAX_LEN);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Advance the string counts; drop them when a finish completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q   <= '0;
			other_count_q <= '0;
		end else if (drain_end) begin
			ref_count_q   <= '0;
			other_count_q <= '0;
		end else begin
			if (do_load) begin
				ref_count_q <= ref_count_q + LEN_W'(1);
			end
			if (do_proc) begin
				other_count_q <= other_count_q + LEN_W'(1);
			end
		end
	end

	// Wait for the best to reach the end of the row, then emit it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			drain_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= drain_end;
			if (do_finish) begin
				busy_q  <= 1'b1;
				drain_q <= LEN_W'(MAX_LEN - 1);
			end else if (drain_end) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				drain_q <= drain_q - LEN_W'(1);
			end
		end
	end

	// Capture the result, saturated to the output width
	always_ff @(posedge clk) begin
		if (drain_end) begin
			if (LEN_W > OUT_W && row_best > LEN_W'({OUT_W{1'b1}})) begin
				best_q <= '1;
			end else begin
				best_q <= OUT_W'(row_best);
			end
		end
	end

	lcsl_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.load_en  (do_load),
		.load_idx (ref_count_q[IDX_W-1:0]),
		.best     (row_best)
	);

	assign busy        = busy_q;
	assign done        = done_q;
	assign best_length = best_q;

	// A result only follows a finish that held the block busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result without a preceding finish");

	// The counts are cleared when the result appears
	a_clear_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (ref_count_q == '0) && (other_count_q == '0))
		else $error("state not cleared with the result");

	// The counts never pass the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(ref_count_q) <= CMP_W'(MAX_LEN)) && (CMP_W'(other_count_q) <= CMP_W'(MAX_LEN)))
		else $error("count beyond row length");

	// Nothing enters the row while a finish drains
	a_no_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(other_count_q) || done_q)
		else $error("work taken while busy");

endmodule

/* hw/rtl/lcsl_cell.sv */
module lcsl_cell import lcsl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lcsl_ctrl_t       ctrl,
	input  logic             wr_en,
	input  logic [LEN_W-1:0] run_left,
	input  logic [LEN_W-1:0] pass_left,
	output logic [LEN_W-1:0] run,
	output logic [LEN_W-1:0] pass
);

	logic [CHAR_W-1:0] char_q;
	logic              valid_q;
	logic [LEN_W-1:0]  run_q;
	logic [LEN_W-1:0]  pass_q;
	logic [LEN_W-1:0]  cand;
	logic              hit;

	assign hit  = valid_q && (char_q == ctrl.ch);
	assign cand = (pass_left > run_q) ? pass_left : run_q;

	// Hold the reference character of this column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			char_q <= ctrl.ch;
		end
	end

	// Extend the diagonal run and fold it into the running best handed right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			run_q   <= '0;
			pass_q  <= '0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			run_q   <= '0;
			pass_q  <= '0;
		end else begin
			if (wr_en) begin
				valid_q <= 1'b1;
				run_q   <= '0;
			end else if (ctrl.proc) begin
				run_q <= hit ? LEN_W'(run_left + LEN_W'(1)) : '0;
			end
			if (cand > pass_q) begin
				pass_q <= cand;
			end
		end
	end

	assign run  = run_q;
	assign pass = pass_q;

endmodule

/* hw/rtl/lcsl_row.sv */
module lcsl_row import lcsl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lcsl_ctrl_t       ctrl,
	input  logic             load_en,
	input  logic [IDX_W-1:0] load_idx,
	output logic [LEN_W-1:0] best
);

	logic [LEN_W-1:0] run_w  [MAX_LEN];
	logic [LEN_W-1:0] pass_w [MAX_LEN];

	// Build the row; column zero sees an empty left neighbor
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		logic             wr_en;
		logic [LEN_W-1:0] run_left;
		logic [LEN_W-1:0] pass_left;

		assign wr_en = load_en && (load_idx == IDX_W'(k));

		if (k == 0) begin : g_first
			assign run_left  = '0;
			assign pass_left = '0;
		end else begin : g_rest
			assign run_left  = run_w[k-1];
			assign pass_left = pass_w[k-1];
		end

		lcsl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.wr_en     (wr_en),
			.run_left  (run_left),
			.pass_left (pass_left),
			.run       (run_w[k]),
			.pass      (pass_w[k])
		);
	end

	assign best = pass_w[MAX_LEN-1];

endmodule

/* tb/sv/lcsl_checker.sv */
`timescale 1ns / 1ps

module lcsl_checker import lcsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        action,
	input  logic [CHAR_W-1:0] char_value,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data,
	input  logic              done,
	input  logic [OUT_W-1:0]  best_length,
	output int                fails,
	output int                pending,
	output int                results,
	output int                top_best
);

	// Mirror of the comparison row
	logic [CHAR_W-1:0] ref_chars [MAX_LEN];
	int                run_len [MAX_LEN];
	int                ref_cnt = 0;
	int                oth_cnt = 0;
	int                best = 0;
	logic [CAP_W-1:0]  cap = 9'd256;

	// Best lengths owed by finish requests, oldest first
	logic [OUT_W-1:0]  owed_best [$];
	logic [OUT_W-1:0]  want;

	int n_fail = 0;
	int n_owed = 0;
	int n_results = 0;
	int n_top = 0;

	assign fails    = n_fail;
	assign pending  = n_owed;
	assign results  = n_results;
	assign top_best = n_top;

	function automatic int cap_limit();
		return (cap > MAX_LEN) ? MAX_LEN : int'(cap);
	endfunction

	task automatic clear_row();
		for (int j = 0; j < MAX_LEN; j++) begin
			ref_chars[j] = '0;
			run_len[j]   = 0;
		end
		ref_cnt = 0;
		oth_cnt = 0;
		best    = 0;
	endtask

	// Advance the run lengths by one character of the other string
	task automatic advance_row(input logic [CHAR_W-1:0] ch);
		int prev;
		for (int k = ref_cnt - 1; k >= 0; k--) begin
			if (ref_chars[k] == ch) begin
				prev = (k > 0) ? run_len[k-1] : 0;
				run_len[k] = prev + 1;
				if (run_len[k] > best)
					best = run_len[k];
			end else begin
				run_len[k] = 0;
			end
		end
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap = 9'd256;
			clear_row();
			owed_best.delete();
			n_owed <= 0;
		end else begin
			// Take a register write
			if (cfg_wr_en)
				cap = cfg_wr_data;

			// Match a result against the oldest owed best
			if (done) begin
				if (owed_best.size() == 0) begin
					flag_mismatch($sformatf("best_length %0d with no finish outstanding",
						best_length));
				end else begin
					want = owed_best.pop_front();
					n_results++;
					if (best_length !== want)
						flag_mismatch($sformatf("best_length %0d, want %0d",
							best_length, want));
				end
			end

			// Apply an accepted request
			if (start && !busy) begin
				case (action)
					ACT_LOAD: begin
						if (ref_cnt < cap_limit()) begin
							ref_chars[ref_cnt] = char_value;
							run_len[ref_cnt]   = 0;
							ref_cnt++;
						end
					end
					ACT_PROC: begin
						if (oth_cnt < cap_limit()) begin
							advance_row(char_value);
							oth_cnt++;
						end
					end
					ACT_FINISH: begin
						owed_best.push_back((best > 511) ? 9'd511 : OUT_W'(best));
						if (best > n_top)
							n_top = best;
						clear_row();
					end
					default: begin
					end
				endcase
			end

			n_owed <= owed_best.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lcsl_pkg::*;

	localparam int ITEMS          = 1750;
	localparam int MIN_RESULTS    = 48;
	localparam int SETTLE         = 8;
	localparam int WATCHDOG_LIMIT = 4 * (MAX_LEN + 64);
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        action = ACT_LOAD;
	logic [CHAR_W-1:0] char_value = '0;
	logic              cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]  cfg_wr_data = '0;
	logic              busy;
	logic              done;
	logic [OUT_W-1:0]  best_length;

	int fails, pending, results, top_best;

	int n_items = 0;
	int n_pairs = 0;
	int n_cap_writes = 0;
	int stall_cycles = 0;
	int cur_cap = 256;
	bit idling = 1'b0;

	// Character source of the current string pair
	logic [CHAR_W-1:0] alphabet [4];
	int                alphabet_n;
	bit                wide_chars;

	longest_common_substring_len u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.char_value (char_value),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done       (done),
		.best_length(best_length)
	);

	lcsl_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.char_value (char_value),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done       (done),
		.best_length(best_length),
		.fails      (fails),
		.pending    (pending),
		.results    (results),
		.top_best   (top_best)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_wr_en)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("longest_common_substring_len test failed");
				$finish;
			end
		end
	end

	// Hold one request until it is taken, then maybe idle for a burst
	task automatic send(input logic [1:0] act, input logic [CHAR_W-1:0] ch);
		start      <= 1'b1;
		action     <= act;
		char_value <= ch;
		do @(posedge clk); while (busy !== 1'b0);
		if (act != ACT_UNUSED)
			n_items++;
		if (idling && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Occasionally slip in an unused action ahead of the request
	task automatic feed(input logic [1:0] act, input logic [CHAR_W-1:0] ch);
		if ($urandom_range(0, 39) == 0)
			send(ACT_UNUSED, CHAR_W'($urandom));
		send(act, ch);
	endtask

	// Drain, let the row settle, then write compare_cap
	task automatic write_cap(input int v);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy !== 1'b0);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CAP_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_cap = v;
		n_cap_writes++;
	endtask

	function automatic int pick_cap();
		case ($urandom_range(0, 15))
			0:       return 0;
			1:       return 1;
			2:       return 255;
			3:       return 256;
			4:       return $urandom_range(257, 511);
			default: return $urandom_range(2, 24);
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] next_char();
		if (wide_chars)
			return CHAR_W'($urandom);
		return alphabet[$urandom_range(0, alphabet_n - 1)];
	endfunction

	// One random string pair, mostly well formed
	task automatic random_pair();
		logic [CHAR_W-1:0] ref_s [$];
		logic [CHAR_W-1:0] oth_s [$];
		int lim, n_ref, n_oth, s, l;
		bit mixed, recap;

		wide_chars = ($urandom_range(0, 3) == 0);
		alphabet_n = $urandom_range(1, 4);
		foreach (alphabet[i])
			alphabet[i] = CHAR_W'($urandom);
		idling = (n_items < ITEMS - 250) && ($urandom_range(0, 3) != 0);

		// Keep most strings short, a few run past the cap
		lim = ((cur_cap > MAX_LEN) ? MAX_LEN : cur_cap) + 2;
		if (lim > 20)
			lim = ($urandom_range(0, 15) == 0) ? ((lim > 80) ? 80 : lim) : 20;
		n_ref = $urandom_range(0, lim);
		for (int i = 0; i < n_ref; i++)
			ref_s.push_back(next_char());

		// Plant a slice of the reference inside the other string
		if (n_ref > 0 && $urandom_range(0, 1) == 1) begin
			s = $urandom_range(0, n_ref - 1);
			l = $urandom_range(1, n_ref - s);
			repeat ($urandom_range(0, 3)) oth_s.push_back(next_char());
			for (int i = s; i < s + l; i++)
				oth_s.push_back(ref_s[i]);
			repeat ($urandom_range(0, 3)) oth_s.push_back(next_char());
		end else begin
			n_oth = $urandom_range(0, lim);
			for (int i = 0; i < n_oth; i++)
				oth_s.push_back(next_char());
		end

		mixed = ($urandom_range(0, 9) == 0);
		recap = ($urandom_range(0, 9) == 0);
		if (!mixed) begin
			foreach (ref_s[i])
				feed(ACT_LOAD, ref_s[i]);
			if (recap)
				write_cap(pick_cap());
			foreach (oth_s[i])
				feed(ACT_PROC, oth_s[i]);
		end else begin
			// Interleave loads with processing
			while (ref_s.size() != 0 || oth_s.size() != 0) begin
				if (oth_s.size() == 0 || (ref_s.size() != 0 && $urandom_range(0, 1) == 0))
					feed(ACT_LOAD, ref_s.pop_front());
				else
					feed(ACT_PROC, oth_s.pop_front());
			end
		end

		// Now and then carry the state into the next pair
		if ($urandom_range(0, 19) != 0) begin
			feed(ACT_FINISH, CHAR_W'($urandom));
			n_pairs++;
		end
	endtask

	initial begin
		logic [CHAR_W-1:0] full_ref [$];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty strings on both sides
		send(ACT_FINISH, 16'hFFFF);
		// Extreme code units; an unused action must leave the row alone
		send(ACT_LOAD, 16'h0000);
		send(ACT_LOAD, 16'hFFFF);
		send(ACT_LOAD, 16'hA5A5);
		send(ACT_PROC, 16'hFFFF);
		send(ACT_UNUSED, 16'hFFFF);
		send(ACT_PROC, 16'hA5A5);
		send(ACT_PROC, 16'h0000);
		send(ACT_FINISH, 16'h0000);
		// Reference loaded after processing started
		send(ACT_PROC, 16'h1234);
		send(ACT_LOAD, 16'h1234);
		send(ACT_PROC, 16'h1234);
		send(ACT_FINISH, 16'h0000);
		// Empty other string
		send(ACT_LOAD, 16'h5A5A);
		send(ACT_FINISH, 16'h0000);
		// Nothing is taken with a zero cap
		write_cap(0);
		send(ACT_LOAD, 16'h0007);
		send(ACT_PROC, 16'h0007);
		send(ACT_FINISH, 16'h0000);
		// Characters beyond a cap of two drop out
		write_cap(2);
		send(ACT_LOAD, 16'h0001);
		send(ACT_LOAD, 16'h0002);
		send(ACT_LOAD, 16'h0003);
		send(ACT_PROC, 16'h0001);
		send(ACT_PROC, 16'h0002);
		send(ACT_PROC, 16'h0003);
		send(ACT_FINISH, 16'h0000);
		n_pairs = 6;

		// Full-length identical strings plus one character past the cap
		write_cap(MAX_LEN);
		for (int i = 0; i <= MAX_LEN; i++)
			full_ref.push_back(CHAR_W'($urandom));
		foreach (full_ref[i])
			send(ACT_LOAD, full_ref[i]);
		foreach (full_ref[i])
			send(ACT_PROC, full_ref[i]);
		send(ACT_FINISH, 16'h0000);
		n_pairs++;

		// Random pairs under changing caps
		while (n_items < ITEMS || n_pairs < MIN_RESULTS) begin
			if ($urandom_range(0, 4) == 0)
				write_cap(pick_cap());
			random_pair();
		end

		// Drain and give a stray result time to show up
		start  <= 1'b0;
		idling = 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (MAX_LEN + SETTLE) @(posedge clk);

		$display("Covered %0d requests in %0d string pairs under %0d compare_cap writes",
			n_items, n_pairs, n_cap_writes);
		$display("Checked %0d best lengths, longest common run %0d", results, top_best);
		if (fails == 0 && pending == 0)
			$display("longest_common_substring_len test passed");
		else
			$display("longest_common_substring_len test failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/lcsl_pkg.sv
hw/rtl/lcsl_cell.sv
hw/rtl/lcsl_row.sv
hw/rtl/longest_common_substring_len.sv
tb/sv/lcsl_checker.sv
tb/sv/tb.sv
